// ----- rtl/sd7_pkg.sv -----
// sd7_pkg: shared types, constants and helpers for the signed decimal
// seven-segment formatter; used by every module under rtl
package sd7_pkg;

    localparam logic [7:0]  SEG_BLANK   = 8'h00;
    localparam logic [7:0]  SEG_MINUS   = 8'b0100_0000;
    localparam logic [7:0]  SEG_POINT   = 8'h80;
    localparam logic [7:0]  SEG_O       = 8'b0011_1111;
    localparam logic [7:0]  SEG_F       = 8'b0111_0001;
    localparam logic [15:0] LIM_NEG     = 16'd999;
    localparam logic [15:0] LIM_POS     = 16'd9999;
    localparam logic [2:0]  DP_LAST     = 3'd2;
    localparam logic [1:0]  POS_RIGHT   = 2'd3;
    localparam logic [1:0]  POS_LEFT    = 2'd0;
    localparam logic [31:0] DIV10_MUL   = 32'd52429;

    typedef struct packed {
        logic [3:0][7:0] segs;
        logic [13:0]     mag;
        logic [2:0]      dp;
        logic [1:0]      pos;
        logic            minus_pending;
        logic            ovf;
    } t_cell;

    // floor(x / 10) for x below 81920, by reciprocal multiply
    function automatic logic [15:0] div10(input logic [15:0] x);
        logic [31:0] p;
        p = {16'd0, x} * DIV10_MUL;
        return 16'(p[31:19]);
    endfunction

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'b0011_1111;
            4'd1: s = 8'b0000_0110;
            4'd2: s = 8'b0101_1011;
            4'd3: s = 8'b0100_1111;
            4'd4: s = 8'b0110_0110;
            4'd5: s = 8'b0110_1101;
            4'd6: s = 8'b0111_1101;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7f;
            4'd9: s = 8'h6f;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/sd7_prep.sv -----
// sd7_prep: front stage, magnitude, range check, scaling and overflow pattern
// depends on sd7_pkg
module sd7_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_value,
    input  logic [2:0]           i_point_position,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sd7_pkg::t_cell       o_data
);
    import sd7_pkg::*;

    logic        r_valid;
    t_cell       r_data;
    t_cell       n_data;
    logic        neg;
    logic [15:0] mag;
    logic        too_big;
    logic [13:0] mag_div;

    assign neg     = i_value[15];
    assign mag     = neg ? (~i_value + 16'd1) : i_value;
    assign too_big = neg ? (mag > LIM_NEG) : (mag > LIM_POS);
    assign mag_div = 14'(div10(mag));

    always_comb begin
        n_data               = '0;
        n_data.pos           = POS_RIGHT;
        n_data.minus_pending = neg;
        n_data.dp            = i_point_position;
        n_data.mag           = mag[13:0];
        if (too_big && (i_point_position > DP_LAST)) begin
            n_data.ovf     = 1'b1;
            n_data.mag     = '0;
            n_data.segs[0] = neg ? SEG_MINUS : SEG_BLANK;
            n_data.segs[1] = SEG_BLANK;
            n_data.segs[2] = SEG_O | SEG_POINT;
            n_data.segs[3] = SEG_F | SEG_POINT;
        end else if (too_big) begin
            n_data.mag = mag_div;
            n_data.dp  = i_point_position + 3'd1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/sd7_cell.sv -----
// sd7_cell: one digit cell, peels the low decimal digit and draws its pattern
// depends on sd7_pkg
module sd7_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sd7_pkg::t_cell       i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sd7_pkg::t_cell       o_data
);
    import sd7_pkg::*;

    logic        r_valid;
    t_cell       r_data;
    t_cell       n_data;
    logic [13:0] q;
    logic [13:0] q10;
    logic [3:0]  d;
    logic [7:0]  s;
    logic        mp;

    assign q   = 14'(div10({2'b00, i_data.mag}));
    assign q10 = {q[10:0], 3'b000} + {q[12:0], 1'b0};
    assign d   = 4'(i_data.mag - q10);

    always_comb begin
        n_data = i_data;
        s      = seg_of(d);
        mp     = i_data.minus_pending;
        if (({1'b0, i_data.pos} < i_data.dp) && (i_data.mag == '0)) begin
            if (mp) begin
                s  = SEG_MINUS;
                mp = 1'b0;
            end else begin
                s = SEG_BLANK;
            end
        end
        if (({1'b0, i_data.pos} == i_data.dp) && (i_data.pos != POS_RIGHT)) begin
            if (mp && (i_data.pos == POS_LEFT) && (d == 4'd0)) begin
                s = SEG_MINUS;
            end
            s = s | SEG_POINT;
        end
        if (!i_data.ovf) begin
            n_data.segs[i_data.pos] = s;
            n_data.mag              = q;
            n_data.minus_pending    = mp;
            n_data.pos              = i_data.pos - 2'd1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/signed_decimal_to_seven_segment.sv -----
// signed_decimal_to_seven_segment: top level, front stage and four digit cells
// depends on sd7_pkg, sd7_prep, sd7_cell
//
//  channel  dir  tdata                                    tuser
//  s        in   [15:0] value, [18:16] point_position     -
//  m        out  [7:0] digit0 .. [31:24] digit3 segments  [0] overflow_shown
//
// one beat per cycle sustained while i_m_tready is high; each beat passes
// one front stage and one register per digit cell
// every stage holds one beat and takes a new one when it is empty or moving,
// so bubbles close up while the output stalls
// synchronous active-low reset empties all stages
module signed_decimal_to_seven_segment (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // value, point_position
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // digit0, digit1, digit2, digit3 segments
    output logic        o_m_tuser    // overflow_shown
);
    import sd7_pkg::*;

    logic        valid [0:4];
    logic        ready [0:4];
    t_cell       data  [0:4];

    sd7_prep u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_value          (i_s_tdata[15:0]),
        .i_point_position (i_s_tdata[18:16]),
        .o_valid          (valid[0]),
        .i_ready          (ready[0]),
        .o_data           (data[0])
    );

    for (genvar g = 0; g < 4; g++) begin : g_cell
        sd7_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[g]),
            .o_ready (ready[g]),
            .i_data  (data[g]),
            .o_valid (valid[g+1]),
            .i_ready (ready[g+1]),
            .o_data  (data[g+1])
        );
    end

    assign ready[4]   = i_m_tready;
    assign o_m_tvalid = valid[4];
    assign o_m_tdata  = data[4].segs;
    assign o_m_tuser  = data[4].ovf;

endmodule
